@@ rtl/emst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package emst_pkg;

  // register map
  localparam logic        RegIdxPeriod = 1'b0;
  localparam logic [15:0] PeriodReset  = 16'd6554;

  // angle constants in 2^-24 rad
  localparam logic signed [28:0] PiS      = 29'sd52707179;
  localparam logic signed [28:0] TwoPiS   = 29'sd105414357;
  localparam logic        [26:0] PiU      = 27'd52707179;
  localparam logic        [26:0] HalfPiU  = 27'd26353589;
  localparam logic        [26:0] QuartPiU = 27'd13176795;

  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  // divisor floors: 66 * 128 for speed, 1049 * 256 for yaw rate
  localparam logic [31:0] SpeedFloorDen = 32'd8448;
  localparam logic [31:0] YawFloorDen   = 32'd268544;

  localparam logic [5:0] DivSteps = 6'd48;

  typedef struct packed {
    logic              present;
    logic              no_lane;
    logic              adas;
    logic              acc;
    logic              pilot;
    logic              nnp;
    logic signed [15:0] speed;
    logic signed [15:0] yaw;
  } in_item_t;

  typedef struct packed {
    logic              valid_res;
    logic              laneless_adas;
    logic              only_acc;
    logic              pilot_engaged;
    logic signed [15:0] forward_step;
    logic signed [15:0] lateral_step;
    logic signed [15:0] heading_step;
    logic signed [15:0] cos_heading;
    logic signed [15:0] sin_heading;
    logic signed [15:0] x_shift;
    logic signed [15:0] y_shift;
    logic signed [15:0] ctrv_lateral_step;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [47:0] quo;
  } div_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [63:0] v);
    if (v > 64'sd16384) return 16'sd16384;
    else if (v < -64'sd16384) return -16'sd16384;
    else return v[15:0];
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                    input int unsigned n);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (n - 1);
    return (v + bias) >>> n;
  endfunction

  function automatic logic [15:0] div_sat(input logic [47:0] q, input logic neg);
    if (neg) begin
      if (q > 48'd32768) return 16'h8000;
      else return 16'(17'd0 - q[16:0]);
    end else if (q > 48'd32767) begin
      return 16'h7fff;
    end else begin
      return q[15:0];
    end
  endfunction

  // taylor divisors: sine levels then cosine levels
  function automatic logic [6:0] series_div(input logic [2:0] k);
    case (k)
      3'd0:    return 7'd72;
      3'd1:    return 7'd42;
      3'd2:    return 7'd20;
      3'd3:    return 7'd6;
      3'd4:    return 7'd56;
      3'd5:    return 7'd30;
      3'd6:    return 7'd12;
      default: return 7'd2;
    endcase
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] series_recip(input logic [2:0] k);
    case (k)
      3'd0:    return 32'd59652323;
      3'd1:    return 32'd102261126;
      3'd2:    return 32'd214748364;
      3'd3:    return 32'd715827882;
      3'd4:    return 32'd76695844;
      3'd5:    return 32'd143165576;
      3'd6:    return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/ego_motion_step_transform_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// ego-motion step transform: per tick, forward, lateral and heading steps, cos and sin of
// the heading step, the translation of the 2-d rigid transform and a constant-turn-rate
// lateral step, all 16-bit fixed point with saturation. one item is worked at a time:
// in_ready_o is high only while the sequencer is idle. a tick with inputs_present low
// goes from idle straight to the done state with an all-zero result and leaves the kept
// yaw rate alone. a normal tick's time from acceptance to the output register is set by
// the two 48-step restoring divisions on the shared divider (lateral step, then turn-radius
// step), run back to back, with the trig series running on the shared 33x33 multiplier
// during the first. the finished result sits in an output register, so the next item can
// be taken while it waits for out_ready_i; a stalled output holds the sequencer in its done
// state. sample_period is at apb byte addresses 0 to 3 (only paddr[2] is decoded) and reads
// back; addresses 4 to 7 are ignored.

module ego_motion_step_transform_top import emst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               inputs_present_i,
  input  logic               no_lane_perception_i,
  input  logic               adas_pilot_mode_i,
  input  logic               acc_active_i,
  input  logic               pilot_engaged_in_i,
  input  logic               nnp_engaged_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] yaw_rate_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic               laneless_adas_o,
  output logic               only_acc_o,
  output logic               pilot_engaged_o,
  output logic signed [15:0] forward_step_o,
  output logic signed [15:0] lateral_step_o,
  output logic signed [15:0] heading_step_o,
  output logic signed [15:0] cos_heading_o,
  output logic signed [15:0] sin_heading_o,
  output logic signed [15:0] x_shift_o,
  output logic signed [15:0] y_shift_o,
  output logic signed [15:0] ctrv_lateral_step_o
);

  logic [15:0] period_q;
  logic        cfg_wr;
  logic        seq_idle, seq_done, out_load;
  logic        out_valid_q;
  res_t        seq_res, out_q;
  in_item_t    item;

  // register write lands on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegIdxPeriod);
  assign prdata = (paddr[2] == RegIdxPeriod) ? {16'd0, period_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_wr) begin
      period_q <= pwdata[15:0];
    end
  end

  assign item.present = inputs_present_i;
  assign item.no_lane = no_lane_perception_i;
  assign item.adas    = adas_pilot_mode_i;
  assign item.acc     = acc_active_i;
  assign item.pilot   = pilot_engaged_in_i;
  assign item.nnp     = nnp_engaged_i;
  assign item.speed   = speed_i;
  assign item.yaw     = yaw_rate_i;

  assign in_ready_o = seq_idle;

  emst_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .start_i  (in_valid_i & seq_idle),
    .item_i   (item),
    .taken_i  (out_load),
    .idle_o   (seq_idle),
    .done_o   (seq_done),
    .res_o    (seq_res)
  );

  // output register, refilled once the previous item leaves
  assign out_load = seq_done & (!out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign valid_res_o         = out_q.valid_res;
  assign laneless_adas_o     = out_q.laneless_adas;
  assign only_acc_o          = out_q.only_acc;
  assign pilot_engaged_o     = out_q.pilot_engaged;
  assign forward_step_o      = out_q.forward_step;
  assign lateral_step_o      = out_q.lateral_step;
  assign heading_step_o      = out_q.heading_step;
  assign cos_heading_o       = out_q.cos_heading;
  assign sin_heading_o       = out_q.sin_heading;
  assign x_shift_o           = out_q.x_shift;
  assign y_shift_o           = out_q.y_shift;
  assign ctrv_lateral_step_o = out_q.ctrv_lateral_step;

endmodule

`default_nettype wire

@@ rtl/emst_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module emst_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [65:0] full;
  logic signed [63:0] p_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= full[63:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/emst_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module emst_div import emst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] work_q, work_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_sh;
  logic        ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[31:0], work_q[47]};
    ge     = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivSteps;
      work_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      work_d = {work_q[46:0], ge};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = work_q;

endmodule

`default_nettype wire

@@ rtl/emst_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module emst_seq import emst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [15:0] period_i,
  input  logic       start_i,
  input  in_item_t   item_i,
  input  logic       taken_i,
  output logic       idle_o,
  output logic       done_o,
  output res_t       res_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MSPD  = 5'd1;
  localparam logic [4:0] S_FWD   = 5'd2;
  localparam logic [4:0] S_HEAD  = 5'd3;
  localparam logic [4:0] S_FSQ   = 5'd4;
  localparam logic [4:0] S_LNUM  = 5'd5;
  localparam logic [4:0] S_X2R   = 5'd6;
  localparam logic [4:0] S_PA    = 5'd7;
  localparam logic [4:0] S_PB    = 5'd8;
  localparam logic [4:0] S_PC    = 5'd9;
  localparam logic [4:0] S_PD    = 5'd10;
  localparam logic [4:0] S_SFIN  = 5'd11;
  localparam logic [4:0] S_SRES  = 5'd12;
  localparam logic [4:0] S_TEND  = 5'd13;
  localparam logic [4:0] S_CQ    = 5'd14;
  localparam logic [4:0] S_CNUM  = 5'd15;
  localparam logic [4:0] S_XA    = 5'd16;
  localparam logic [4:0] S_XB    = 5'd17;
  localparam logic [4:0] S_YA    = 5'd18;
  localparam logic [4:0] S_YB    = 5'd19;
  localparam logic [4:0] S_CWAIT = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0] state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic       cos_ser_q, cos_ser_d;
  logic signed [15:0] prev_yaw_q, prev_yaw_d;

  in_item_t item_q, item_d;
  logic signed [15:0] fwd_q, fwd_d, head_q, head_d, lat_q, lat_d;
  logic signed [15:0] cq_q, cq_d, sq_q, sq_d, xs_q, xs_d, ys_q, ys_d, ctrv_q, ctrv_d;
  logic [29:0] x_q, x_d;
  logic        swap_q, swap_d, negc_q, negc_d, negs_q, negs_d;
  logic [30:0] x2_q, x2_d, t_q, t_d, sres_q, sres_d;
  logic [31:0] y_q, y_d, q0_q, q0_d;
  logic signed [31:0] c30_q, c30_d, s30_q, s30_d, acc_q, acc_d;

  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic signed [15:0] spd, yaw;
  logic [15:0] ayp, aspd, ayaw;
  logic [31:0] den_lat, den_ctrv;
  logic        yaw_big, neg_w, neg_ctrv;
  logic signed [28:0] ang_a, ang_r;
  logic [26:0] ang_m, ang_f;
  logic        fold_negc, fold_swap;
  logic [29:0] fold_x;
  logic [2:0]  ser_k;
  logic [6:0]  ser_d;
  logic [31:0] pd_r, pd_q;
  logic [30:0] c_raw, s_raw;
  logic signed [31:0] c_mag, s_mag;
  logic signed [32:0] omc;
  logic signed [63:0] mix;

  emst_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  emst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // operand preparation
  always_comb begin
    spd  = item_q.speed;
    yaw  = item_q.yaw;
    ayp  = prev_yaw_q[15] ? 16'(-prev_yaw_q) : prev_yaw_q;
    aspd = spd[15] ? 16'(-spd) : spd;
    ayaw = yaw[15] ? 16'(-yaw) : yaw;
    den_lat  = (spd > 16'sd0) ? 32'({spd[14:0], 15'd0}) : SpeedFloorDen;
    yaw_big  = (yaw > 16'sd4) || (yaw < -16'sd4);
    den_ctrv = yaw_big ? {ayaw, 16'd0} : YawFloorDen;
    neg_w    = yaw_big ? yaw[15] : !(yaw > 16'sd0);
    neg_ctrv = spd[15] ^ neg_w;

    // heading fold to [0, pi/4]
    ang_a = $signed({head_q[15], head_q, 12'd0});
    if (ang_a > PiS) ang_r = ang_a - TwoPiS;
    else if (ang_a < -PiS) ang_r = ang_a + TwoPiS;
    else ang_r = ang_a;
    ang_m     = ang_r[28] ? 27'(-ang_r) : 27'(ang_r);
    fold_negc = ang_m > HalfPiU;
    ang_f     = fold_negc ? PiU - ang_m : ang_m;
    fold_swap = ang_f > QuartPiU;
    fold_x    = fold_swap ? 30'({HalfPiU - ang_f, 6'd0}) : 30'({ang_f, 6'd0});

    ser_k = {cos_ser_q, lvl_q};
    ser_d = series_div(ser_k);
    pd_r  = y_q - prod[31:0];
    pd_q  = q0_q + 32'(pd_r >= 32'(ser_d));

    c_raw = swap_q ? sres_q : t_q;
    s_raw = swap_q ? t_q : sres_q;
    c_mag = $signed({1'b0, c_raw});
    s_mag = $signed({1'b0, s_raw});
    omc   = 33'sh0_4000_0000 - 33'(c30_q);
  end

  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    cos_ser_d  = cos_ser_q;
    prev_yaw_d = prev_yaw_q;
    item_d  = item_q;
    fwd_d   = fwd_q;
    head_d  = head_q;
    lat_d   = lat_q;
    cq_d    = cq_q;
    sq_d    = sq_q;
    xs_d    = xs_q;
    ys_d    = ys_q;
    ctrv_d  = ctrv_q;
    x_d     = x_q;
    swap_d  = swap_q;
    negc_d  = negc_q;
    negs_d  = negs_q;
    x2_d    = x2_q;
    t_d     = t_q;
    sres_d  = sres_q;
    y_d     = y_q;
    q0_d    = q0_q;
    c30_d   = c30_q;
    s30_d   = s30_q;
    acc_d   = acc_q;
    mix     = '0;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          state_d = item_i.present ? S_MSPD : S_DONE;
        end
      end
      S_MSPD: begin
        mul_en  = 1'b1;
        mul_a   = 33'(spd);
        mul_b   = 33'(period_i);
        state_d = S_FWD;
      end
      S_FWD: begin
        fwd_d   = sat16(round_shift(prod, 14));
        mul_en  = 1'b1;
        mul_a   = 33'(yaw);
        mul_b   = 33'(period_i);
        state_d = S_HEAD;
      end
      S_HEAD: begin
        head_d  = sat16(round_shift(prod, 16));
        mul_en  = 1'b1;
        mul_a   = 33'(fwd_q);
        mul_b   = 33'(fwd_q);
        state_d = S_FSQ;
      end
      S_FSQ: begin
        mul_en  = 1'b1;
        mul_a   = prod[32:0];
        mul_b   = 33'(ayp);
        x_d     = fold_x;
        swap_d  = fold_swap;
        negc_d  = fold_negc;
        negs_d  = ang_r[28];
        state_d = S_LNUM;
      end
      S_LNUM: begin
        div_req.start = 1'b1;
        div_req.num   = prod[47:0] + 48'(den_lat >> 1);
        div_req.den   = den_lat;
        mul_en  = 1'b1;
        mul_a   = 33'(x_q);
        mul_b   = 33'(x_q);
        state_d = S_X2R;
      end
      S_X2R: begin
        x2_d      = prod[60:30];
        t_d       = OneQ30;
        lvl_d     = 2'd0;
        cos_ser_d = 1'b0;
        state_d   = S_PA;
      end
      S_PA: begin
        mul_en  = 1'b1;
        mul_a   = 33'(x2_q);
        mul_b   = 33'(t_q);
        state_d = S_PB;
      end
      S_PB: begin
        y_d     = prod[61:30];
        mul_en  = 1'b1;
        mul_a   = 33'(prod[61:30]);
        mul_b   = 33'(series_recip(ser_k));
        state_d = S_PC;
      end
      S_PC: begin
        q0_d    = prod[63:32];
        mul_en  = 1'b1;
        mul_a   = 33'(prod[63:32]);
        mul_b   = 33'(ser_d);
        state_d = S_PD;
      end
      S_PD: begin
        // quotient estimate is low by at most one
        t_d = OneQ30 - pd_q[30:0];
        if (lvl_q != 2'd3) begin
          lvl_d   = lvl_q + 2'd1;
          state_d = S_PA;
        end else if (!cos_ser_q) begin
          state_d = S_SFIN;
        end else begin
          state_d = S_TEND;
        end
      end
      S_SFIN: begin
        mul_en  = 1'b1;
        mul_a   = 33'(x_q);
        mul_b   = 33'(t_q);
        state_d = S_SRES;
      end
      S_SRES: begin
        sres_d    = prod[60:30];
        t_d       = OneQ30;
        lvl_d     = 2'd0;
        cos_ser_d = 1'b1;
        state_d   = S_PA;
      end
      S_TEND: begin
        c30_d   = negc_q ? -c_mag : c_mag;
        s30_d   = negs_q ? -s_mag : s_mag;
        state_d = S_CQ;
      end
      S_CQ: begin
        cq_d    = clamp_q14(round_shift(64'(c30_q), 16));
        sq_d    = clamp_q14(round_shift(64'(s30_q), 16));
        mul_en  = 1'b1;
        mul_a   = 33'(aspd);
        mul_b   = omc;
        state_d = S_CNUM;
      end
      S_CNUM: begin
        if (!div_rsp.busy) begin
          lat_d = div_sat(div_rsp.quo, prev_yaw_q[15]);
          div_req.start = 1'b1;
          div_req.num   = prod[47:0] + 48'(den_ctrv >> 1);
          div_req.den   = den_ctrv;
          mul_en  = 1'b1;
          mul_a   = 33'(fwd_q);
          mul_b   = 33'(cq_q);
          state_d = S_XA;
        end
      end
      S_XA: begin
        acc_d   = prod[31:0];
        mul_en  = 1'b1;
        mul_a   = 33'(lat_q);
        mul_b   = 33'(sq_q);
        state_d = S_XB;
      end
      S_XB: begin
        mix     = 64'(acc_q) + prod;
        xs_d    = sat16(-round_shift(mix, 14));
        mul_en  = 1'b1;
        mul_a   = 33'(fwd_q);
        mul_b   = 33'(sq_q);
        state_d = S_YA;
      end
      S_YA: begin
        acc_d   = prod[31:0];
        mul_en  = 1'b1;
        mul_a   = 33'(lat_q);
        mul_b   = 33'(cq_q);
        state_d = S_YB;
      end
      S_YB: begin
        mix     = 64'(acc_q) - prod;
        ys_d    = sat16(round_shift(mix, 14));
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        if (!div_rsp.busy) begin
          ctrv_d     = div_sat(div_rsp.quo, neg_ctrv);
          prev_yaw_d = yaw;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (taken_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      lvl_q      <= '0;
      cos_ser_q  <= 1'b0;
      prev_yaw_q <= '0;
    end else begin
      state_q    <= state_d;
      lvl_q      <= lvl_d;
      cos_ser_q  <= cos_ser_d;
      prev_yaw_q <= prev_yaw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    fwd_q  <= fwd_d;
    head_q <= head_d;
    lat_q  <= lat_d;
    cq_q   <= cq_d;
    sq_q   <= sq_d;
    xs_q   <= xs_d;
    ys_q   <= ys_d;
    ctrv_q <= ctrv_d;
    x_q    <= x_d;
    swap_q <= swap_d;
    negc_q <= negc_d;
    negs_q <= negs_d;
    x2_q   <= x2_d;
    t_q    <= t_d;
    sres_q <= sres_d;
    y_q    <= y_d;
    q0_q   <= q0_d;
    c30_q  <= c30_d;
    s30_q  <= s30_d;
    acc_q  <= acc_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);

  // absent inputs give an all-zero result
  always_comb begin
    res_o = '0;
    if (item_q.present) begin
      res_o.valid_res         = 1'b1;
      res_o.laneless_adas     = item_q.no_lane & item_q.adas;
      res_o.only_acc          = item_q.acc & !item_q.pilot & !item_q.nnp;
      res_o.pilot_engaged     = item_q.pilot;
      res_o.forward_step      = fwd_q;
      res_o.lateral_step      = lat_q;
      res_o.heading_step      = head_q;
      res_o.cos_heading       = cq_q;
      res_o.sin_heading       = sq_q;
      res_o.x_shift           = xs_q;
      res_o.y_shift           = ys_q;
      res_o.ctrv_lateral_step = ctrv_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/emst_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module emst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               valid_res_o,
  input logic signed [15:0] forward_step_o,
  input logic signed [15:0] lateral_step_o,
  input logic signed [15:0] cos_heading_o,
  input logic signed [15:0] sin_heading_o,
  input logic signed [15:0] x_shift_o,
  input logic signed [15:0] ctrv_lateral_step_o
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_shift_o))
    else $error("stalled result changed");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> forward_step_o == 16'sd0 && lateral_step_o == 16'sd0
      && cos_heading_o == 16'sd0 && ctrv_lateral_step_o == 16'sd0)
    else $error("absent tick gave nonzero fields");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> cos_heading_o <= 16'sd16384 && cos_heading_o >= -16'sd16384
      && sin_heading_o <= 16'sd16384 && sin_heading_o >= -16'sd16384)
    else $error("cos or sin out of q1.14 range");

endmodule

bind ego_motion_step_transform_top emst_checker u_emst_checker (.*);

`default_nettype wire
